### rtl/bfn_pkg.sv
package bfn_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int PIXEL_ONE = 16;

	localparam logic REG_SCORE_THR = 1'b0;
	localparam logic REG_IOU_THR = 1'b1;

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [14:0] box_width;
		logic [14:0] box_height;
		logic [15:0] cand_score;
		logic [3:0] cand_label;
		logic last_candidate;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [15:0] kept_score;
		logic [3:0] kept_label;
		logic last_box;
		logic empty_set;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic [15:0] score;
		logic [3:0] label;
	} entry_t;

	typedef struct packed {
		logic load_cand;
		logic mem_we;
		logic wr_from_rd;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] rd_addr;
		logic load_i;
		logic mark_we;
		logic ovf_set;
		logic out_load;
		logic out_empty;
		logic out_last;
		logic frame_clear;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic last;
		logic ge;
		logic supp_rd;
		logic out_free;
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_W0,
		ST_END_CHK,
		ST_EMPTY,
		ST_NI_RD,
		ST_NI_LD,
		ST_NJ_RD,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_EM_RD
	} state_t;

endpackage

### rtl/box_filter_nms.sv
// A candidate that is dropped or lands in an empty store is taken without a search;
// otherwise it is inserted by score, and each stored entry of lower score moves up one place.
// After the last candidate, suppression compares the pairs of boxes one at a time
// (one memory read port, one IoU pipeline), then the kept boxes go to the output one by one.
// One candidate is taken at a time; in_ready is high only while the block is waiting.
// Reset clears the box count, suppression flags and overflow, and loads default thresholds.
module box_filter_nms (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bfn_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output bfn_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);
	import bfn_pkg::*;

	cmd_t cmd;
	status_t stat;

	bfn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	bfn_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

### rtl/bfn_dp.sv
module bfn_dp (
	input  logic clk,
	input  logic arst_n,
	input  bfn_pkg::in_item_t in_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	input  bfn_pkg::cmd_t cmd,
	output bfn_pkg::status_t stat,
	output logic out_valid,
	input  logic out_ready,
	output bfn_pkg::out_item_t out_data
);
	import bfn_pkg::*;

	logic [15:0] score_thr_q;
	logic [15:0] iou_thr_q;
	entry_t cand_q;
	logic pass_q;
	logic last_q;
	logic ovf_q;
	entry_t mem [MAX_BOXES];
	entry_t rd_q;
	entry_t ent_i_q;
	logic [MAX_BOXES-1:0] supp_q;
	out_item_t out_q;
	logic out_valid_q;

	logic [16:0] ow_s1, oh_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	logic [33:0] inter_s2, area_a_s2, area_b_s2;
	logic [33:0] inter_s3;
	logic [34:0] uni_s3;
	logic [33:0] inter_s4;
	logic [33:0] p_lo_s4;
	logic [32:0] p_hi_s4;
	logic hit;
	entry_t wr_data;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	function automatic logic [16:0] extent(input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		logic signed [17:0] d;
		d = 18'(hi) - 18'(lo) + 18'sd16;
		if (d[17]) begin
			return 17'd0;
		end else begin
			return d[16:0];
		end
	endfunction

	function automatic logic signed [15:0] smax(input logic signed [15:0] a,
			input logic signed [15:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [15:0] smin(input logic signed [15:0] a,
			input logic signed [15:0] b);
		return (a < b) ? a : b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q <= 16'd39322;
			iou_thr_q <= 16'd19661;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THR: score_thr_q <= cfg_data;
				REG_IOU_THR: iou_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cand) begin
			cand_q.x1 <= sat16(18'(in_data.center_x) - 18'(in_data.box_width[14:1]));
			cand_q.y1 <= sat16(18'(in_data.center_y) - 18'(in_data.box_height[14:1]));
			cand_q.x2 <= sat16(18'(in_data.center_x) + 18'(in_data.box_width[14:1]));
			cand_q.y2 <= sat16(18'(in_data.center_y) + 18'(in_data.box_height[14:1]));
			cand_q.score <= in_data.cand_score;
			cand_q.label <= in_data.cand_label;
			pass_q <= in_data.cand_score > score_thr_q;
			last_q <= in_data.last_candidate;
		end
	end

	assign wr_data = cmd.wr_from_rd ? rd_q : cand_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		rd_q <= mem[cmd.rd_addr];
		if (cmd.load_i) begin
			ent_i_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		ow_s1 <= extent(smax(ent_i_q.x1, rd_q.x1), smin(ent_i_q.x2, rd_q.x2));
		oh_s1 <= extent(smax(ent_i_q.y1, rd_q.y1), smin(ent_i_q.y2, rd_q.y2));
		aw_s1 <= extent(ent_i_q.x1, ent_i_q.x2);
		ah_s1 <= extent(ent_i_q.y1, ent_i_q.y2);
		bw_s1 <= extent(rd_q.x1, rd_q.x2);
		bh_s1 <= extent(rd_q.y1, rd_q.y2);
		inter_s2 <= 34'(ow_s1) * 34'(oh_s1);
		area_a_s2 <= 34'(aw_s1) * 34'(ah_s1);
		area_b_s2 <= 34'(bw_s1) * 34'(bh_s1);
		uni_s3 <= 35'(area_a_s2) + 35'(area_b_s2) - 35'(inter_s2);
		inter_s3 <= inter_s2;
		p_lo_s4 <= 34'(iou_thr_q) * 34'(uni_s3[17:0]);
		p_hi_s4 <= 33'(iou_thr_q) * 33'(uni_s3[34:18]);
		inter_s4 <= inter_s3;
	end

	assign hit = {2'b00, inter_s4, 16'd0} >=
		({1'b0, p_hi_s4, 18'd0} + 52'(p_lo_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supp_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.frame_clear) begin
				supp_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.ovf_set) begin
					ovf_q <= 1'b1;
				end
				if (cmd.mark_we && hit && rd_q.label == ent_i_q.label) begin
					supp_q[cmd.rd_addr] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_empty) begin
				out_q <= '0;
				out_q.last_box <= 1'b1;
				out_q.empty_set <= 1'b1;
				out_q.overflow <= ovf_q;
			end else begin
				out_q.left <= rd_q.x1;
				out_q.top <= rd_q.y1;
				out_q.right <= rd_q.x2;
				out_q.bottom <= rd_q.y2;
				out_q.kept_score <= rd_q.score;
				out_q.kept_label <= rd_q.label;
				out_q.last_box <= cmd.out_last;
				out_q.empty_set <= 1'b0;
				out_q.overflow <= ovf_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign stat.pass = pass_q;
	assign stat.last = last_q;
	assign stat.ge = rd_q.score >= cand_q.score;
	assign stat.supp_rd = supp_q[cmd.rd_addr];
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

### rtl/bfn_ctrl.sv
module bfn_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bfn_pkg::status_t stat,
	output bfn_pkg::cmd_t cmd
);
	import bfn_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic [IDX_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [IDX_W-1:0] keep_q, keep_d;
	logic full;
	logic [CNT_W-1:0] k_up;
	logic [CNT_W-1:0] count_m1;
	logic i_end;
	logic j_end;

	assign full = count_q == CNT_W'(MAX_BOXES);
	assign k_up = CNT_W'(k_q) + CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);
	assign i_end = CNT_W'(i_q) == count_m1;
	assign j_end = CNT_W'(j_q) == count_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			keep_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q <= k_d;
			i_q <= i_d;
			j_q <= j_d;
			keep_q <= keep_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		k_d = k_q;
		i_d = i_q;
		j_d = j_q;
		keep_d = keep_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_cand = 1'b1;
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (!stat.pass) begin
					state_d = ST_END_CHK;
				end else if (count_q == '0) begin
					cmd.mem_we = 1'b1;
					cmd.wr_addr = '0;
					count_d = CNT_W'(1);
					state_d = ST_END_CHK;
				end else begin
					cmd.ovf_set = full;
					k_d = count_m1[IDX_W-1:0];
					state_d = ST_INS_RD;
				end
			end
			ST_INS_RD: begin
				cmd.rd_addr = k_q;
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				cmd.rd_addr = k_q;
				cmd.wr_addr = k_up[IDX_W-1:0];
				if (stat.ge) begin
					cmd.mem_we = k_up != CNT_W'(MAX_BOXES);
					if (!full) begin
						count_d = count_q + CNT_W'(1);
					end
					state_d = ST_END_CHK;
				end else begin
					cmd.mem_we = k_up != CNT_W'(MAX_BOXES);
					cmd.wr_from_rd = 1'b1;
					if (k_q == '0) begin
						state_d = ST_INS_W0;
					end else begin
						k_d = k_q - IDX_W'(1);
						state_d = ST_INS_RD;
					end
				end
			end
			ST_INS_W0: begin
				cmd.mem_we = 1'b1;
				cmd.wr_addr = '0;
				if (!full) begin
					count_d = count_q + CNT_W'(1);
				end
				state_d = ST_END_CHK;
			end
			ST_END_CHK: begin
				i_d = '0;
				k_d = '1;
				if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (count_q == '0) begin
					state_d = ST_EMPTY;
				end else begin
					state_d = ST_NI_RD;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_empty = 1'b1;
					cmd.frame_clear = 1'b1;
					count_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_NI_RD: begin
				cmd.rd_addr = i_q;
				if (stat.supp_rd) begin
					if (i_end) begin
						i_d = '0;
						state_d = ST_EM_RD;
					end else begin
						i_d = i_q + IDX_W'(1);
					end
				end else begin
					keep_d = i_q;
					state_d = ST_NI_LD;
				end
			end
			ST_NI_LD: begin
				cmd.rd_addr = i_q;
				cmd.load_i = 1'b1;
				if (i_end) begin
					i_d = '0;
					state_d = ST_EM_RD;
				end else begin
					j_d = i_q + IDX_W'(1);
					state_d = ST_NJ_RD;
				end
			end
			ST_NJ_RD: begin
				cmd.rd_addr = j_q;
				state_d = ST_P1;
			end
			ST_P1: begin
				cmd.rd_addr = j_q;
				state_d = ST_P2;
			end
			ST_P2: begin
				cmd.rd_addr = j_q;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.rd_addr = j_q;
				state_d = ST_P4;
			end
			ST_P4: begin
				cmd.rd_addr = j_q;
				state_d = ST_P5;
			end
			ST_P5: begin
				cmd.rd_addr = j_q;
				cmd.mark_we = 1'b1;
				if (j_end) begin
					i_d = i_q + IDX_W'(1);
					state_d = ST_NI_RD;
				end else begin
					j_d = j_q + IDX_W'(1);
					state_d = ST_NJ_RD;
				end
			end
			ST_EM_RD: begin
				cmd.rd_addr = i_q;
				cmd.out_last = i_q == keep_q;
				if (stat.supp_rd) begin
					if (i_end) begin
						cmd.frame_clear = 1'b1;
						count_d = '0;
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + IDX_W'(1);
					end
				end else begin
					// Wait for the read data, then hand it to the output register.
					state_d = ST_EM_RD;
					if (k_q == i_q && stat.out_free) begin
						cmd.out_load = 1'b1;
						if (i_end || i_q == keep_q) begin
							cmd.frame_clear = 1'b1;
							count_d = '0;
							state_d = ST_IDLE;
						end else begin
							i_d = i_q + IDX_W'(1);
						end
					end
					k_d = i_q;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import bfn_pkg::*;

	localparam int STALL_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SCORE_THR;
	logic [15:0] cfg_data = '0;

	box_filter_nms DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	in_item_t pending_q[$];
	out_item_t kept_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	logic [15:0] score_thr = 16'd39322;
	logic [15:0] iou_thr = 16'd19661;
	entry_t frame_boxes[$];
	logic frame_ovf = 1'b0;

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic longint extent(logic signed [15:0] lo, logic signed [15:0] hi);
		return longint'(hi) - longint'(lo) + PIXEL_ONE;
	endfunction

	function automatic bit heavy_overlap(entry_t a, entry_t b);
		longint w, h, inter, uni;
		w = ((a.x2 < b.x2) ? a.x2 : b.x2) - longint'((a.x1 > b.x1) ? a.x1 : b.x1) + PIXEL_ONE;
		h = ((a.y2 < b.y2) ? a.y2 : b.y2) - longint'((a.y1 > b.y1) ? a.y1 : b.y1) + PIXEL_ONE;
		if (w < 0) w = 0;
		if (h < 0) h = 0;
		inter = w * h;
		uni = extent(a.x1, a.x2) * extent(a.y1, a.y2)
			+ extent(b.x1, b.x2) * extent(b.y1, b.y2) - inter;
		return inter * 65536 >= longint'(iou_thr) * uni;
	endfunction

	task automatic predict_nms(in_item_t c);
		entry_t e;
		int pos;
		bit gone[$];
		out_item_t r;
		int n;
		if (c.cand_score > score_thr) begin
			e.x1 = clamp16(int'(c.center_x) - int'(c.box_width >> 1));
			e.y1 = clamp16(int'(c.center_y) - int'(c.box_height >> 1));
			e.x2 = clamp16(int'(c.center_x) + int'(c.box_width >> 1));
			e.y2 = clamp16(int'(c.center_y) + int'(c.box_height >> 1));
			e.score = c.cand_score;
			e.label = c.cand_label;
			pos = 0;
			while (pos < frame_boxes.size() && frame_boxes[pos].score >= e.score) pos++;
			if (frame_boxes.size() >= MAX_BOXES) begin
				frame_ovf = 1'b1;
				if (pos < MAX_BOXES) begin
					void'(frame_boxes.pop_back());
					frame_boxes.insert(pos, e);
				end
			end else begin
				frame_boxes.insert(pos, e);
			end
		end
		if (!c.last_candidate) return;
		if (frame_boxes.size() == 0) begin
			r = '0;
			r.last_box = 1'b1;
			r.empty_set = 1'b1;
			r.overflow = frame_ovf;
			kept_q.insert(kept_q.size(), r);
		end else begin
			foreach (frame_boxes[i]) gone.insert(gone.size(), 1'b0);
			foreach (frame_boxes[i]) begin
				if (!gone[i]) begin
					for (int j = i + 1; j < frame_boxes.size(); j++) begin
						if (!gone[j] && frame_boxes[i].label == frame_boxes[j].label
							&& heavy_overlap(frame_boxes[i], frame_boxes[j]))
							gone[j] = 1'b1;
					end
				end
			end
			n = 0;
			foreach (frame_boxes[i]) begin
				if (!gone[i]) begin
					r.left = frame_boxes[i].x1;
					r.top = frame_boxes[i].y1;
					r.right = frame_boxes[i].x2;
					r.bottom = frame_boxes[i].y2;
					r.kept_score = frame_boxes[i].score;
					r.kept_label = frame_boxes[i].label;
					r.last_box = 1'b0;
					r.empty_set = 1'b0;
					r.overflow = frame_ovf;
					kept_q.insert(kept_q.size(), r);
					n++;
				end
			end
			kept_q[kept_q.size() - 1].last_box = 1'b1;
		end
		frame_boxes.delete();
		frame_ovf = 1'b0;
	endtask

	// Driver: predictions are made as each beat is accepted.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_nms(in_data);
		end
		if (!in_valid || in_ready) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver back-pressure.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (kept_q.size() == 0) begin
				$display("%0t: unexpected beat %p", $time, out_data);
				errors++;
			end else if (kept_q[0] !== out_data) begin
				$display("%0t: mismatch expected %p actual %p", $time, kept_q[0], out_data);
				errors++;
				void'(kept_q.pop_front());
			end else begin
				void'(kept_q.pop_front());
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic in_item_t rand_cand(bit last, int base_x, int base_y, int spread);
		in_item_t c;
		c.center_x = 16'(base_x + $urandom_range(2 * spread) - spread);
		c.center_y = 16'(base_y + $urandom_range(2 * spread) - spread);
		c.box_width = 15'($urandom_range(2000, 40));
		c.box_height = 15'($urandom_range(2000, 40));
		c.cand_score = 16'($urandom);
		c.cand_label = 4'($urandom_range(3));
		c.last_candidate = last;
		return c;
	endfunction

	function automatic in_item_t noise_cand(bit last);
		in_item_t c;
		c = in_item_t'({$urandom, $urandom, $urandom});
		c.last_candidate = last;
		return c;
	endfunction

	function automatic in_item_t mk(int cx, int cy, int w, int h, int s, int l, bit last);
		in_item_t c;
		c.center_x = 16'(cx);
		c.center_y = 16'(cy);
		c.box_width = 15'(w);
		c.box_height = 15'(h);
		c.cand_score = 16'(s);
		c.cand_label = 4'(l);
		c.last_candidate = last;
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_q.size() > 0 || in_valid || kept_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCORE_THR) score_thr = val;
		else iou_thr = val;
	endtask

	task automatic queue_frame(int len, int noise_pct);
		int bx, by;
		bx = $urandom_range(4000) - 2000;
		by = $urandom_range(4000) - 2000;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < noise_pct)
				pending_q.insert(pending_q.size(), noise_cand(k == len - 1));
			else
				pending_q.insert(pending_q.size(), rand_cand(k == len - 1, bx, by, 600));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_q.insert(pending_q.size(), mk(0, 0, 32, 32, 39322, 0, 1'b1));
		pending_q.insert(pending_q.size(), mk(0, 0, 32, 32, 39323, 0, 1'b1));
		pending_q.insert(pending_q.size(), mk(-32768, -32768, 32767, 32767, 65535, 15, 1'b0));
		pending_q.insert(pending_q.size(), mk(32767, 32767, 32767, 32767, 65535, 15, 1'b0));
		pending_q.insert(pending_q.size(), mk(100, 100, 160, 160, 50000, 2, 1'b0));
		pending_q.insert(pending_q.size(), mk(104, 100, 160, 160, 50000, 2, 1'b0));
		pending_q.insert(pending_q.size(), mk(104, 100, 160, 160, 60000, 3, 1'b0));
		pending_q.insert(pending_q.size(), mk(900, 900, 0, 0, 45000, 2, 1'b0));
		pending_q.insert(pending_q.size(), mk(-5, 7, 1, 1, 0, 1, 1'b1));
		wait_drained();

		write_reg(REG_SCORE_THR, 16'd0);
		write_reg(REG_IOU_THR, 16'd0);
		pending_q.insert(pending_q.size(), mk(0, 0, 16, 16, 1, 4, 1'b0));
		pending_q.insert(pending_q.size(), mk(5000, 5000, 16, 16, 2, 4, 1'b0));
		pending_q.insert(pending_q.size(), mk(0, 0, 0, 0, 0, 4, 1'b1));
		wait_drained();
		write_reg(REG_IOU_THR, 16'd65535);
		pending_q.insert(pending_q.size(), mk(0, 0, 64, 64, 9, 5, 1'b0));
		pending_q.insert(pending_q.size(), mk(0, 0, 64, 64, 9, 5, 1'b0));
		pending_q.insert(pending_q.size(), mk(1, 0, 64, 64, 8, 5, 1'b1));
		wait_drained();
		write_reg(REG_SCORE_THR, 16'd65535);
		pending_q.insert(pending_q.size(), mk(0, 0, 64, 64, 65535, 5, 1'b1));
		wait_drained();

		// Overflow: more passing candidates than the store holds, with ties.
		write_reg(REG_SCORE_THR, 16'd100);
		write_reg(REG_IOU_THR, 16'd30000);
		for (int k = 0; k < MAX_BOXES + 6; k++)
			pending_q.insert(pending_q.size(),
				mk(k * 64, k * 32, 48, 48, 200 + (k % 7) * 50, k % 3, 1'b0));
		pending_q.insert(pending_q.size(), mk(0, 0, 48, 48, 150, 1, 1'b1));
		hold_cycles = 3000;
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 80; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 80; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			write_reg(REG_SCORE_THR, (ph == 7) ? 16'd0 : 16'($urandom_range(50000)));
			write_reg(REG_IOU_THR, (ph == 6) ? 16'd65535 : 16'($urandom_range(40000)));
			if (ph == 4) hold_cycles = 2000;
			for (int f = 0; f < 4; f++) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 1);
				queue_frame(len, 10);
			end
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
